// File: sv/gcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gcf_pkg;

   // fixed point and pipeline sizes
   localparam int FRAC_BITS    = 16;
   localparam int SQRT_LAT     = 32;
   localparam int DIV_LAT      = 47;
   localparam int QDEPTH       = 8;
   localparam int QAW          = $clog2(QDEPTH);
   localparam int SQ_LANES     = 5;

   // register indexes
   localparam logic [2:0] REG_LEVEL   = 3'd0;
   localparam logic [2:0] REG_MINPEN  = 3'd1;
   localparam logic [2:0] REG_STIFF   = 3'd2;
   localparam logic [2:0] REG_DAMP    = 3'd3;
   localparam logic [2:0] REG_SCOEF   = 3'd4;
   localparam logic [2:0] REG_DCOEF   = 3'd5;
   localparam logic [2:0] REG_SLIDE   = 3'd6;
   localparam logic [2:0] REG_IMPACT  = 3'd7;

   // contact state codes
   localparam logic [1:0] ST_NONE    = 2'd0;
   localparam logic [1:0] ST_CONTACT = 2'd1;
   localparam logic [1:0] ST_SLIP    = 2'd2;
   localparam logic [1:0] ST_IMPACT  = 2'd3;

   localparam logic [46:0] MAX47 = {47{1'b1}};

   typedef struct packed {
      logic [31:0] level;
      logic [30:0] minpen;
      logic [39:0] stiff;
      logic [39:0] damp;
      logic [20:0] scoef;
      logic [20:0] dcoef;
      logic [30:0] slide;
      logic [46:0] impact;
   } cfg_type;

   // word handed from front to back
   typedef struct packed {
      logic        contact;
      logic        sx;
      logic        sy;
      logic [30:0] pen;
      logic [46:0] normal;
      logic [31:0] ax;
      logic [31:0] ay;
   } fw_type;

   // word carried down the back pipeline
   typedef struct packed {
      logic        valid;
      logic        contact;
      logic        sx;
      logic        sy;
      logic [30:0] pen;
      logic [46:0] normal;
      logic [31:0] ax;
      logic [31:0] ay;
      logic [31:0] speed;
      logic [46:0] fric;
      logic        t_big;
      logic [47:0] t_val;
      logic [46:0] mx;
      logic [46:0] my;
   } bk_type;

   typedef struct packed {
      logic [QAW:0] level;
   } qstat_type;

   // saturate a shifted force to 47 bits
   function automatic logic [46:0] sat47(input logic [56:0] v);
      logic [46:0] r;
      if (v[56:47] != '0) r = MAX47;
      else r = v[46:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// File: sv/gcf_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module gcf_isqrt import gcf_pkg::*; (
   input  wire logic        clock,
   input  wire logic [63:0] x,
   output logic      [31:0] root
);
   logic [33:0] rem_d  [SQRT_LAT+1];
   logic [31:0] root_d [SQRT_LAT+1];
   logic [63:0] x_d    [SQRT_LAT+1];
   logic [33:0] rem_ff  [SQRT_LAT];
   logic [31:0] root_ff [SQRT_LAT];
   logic [63:0] x_ff    [SQRT_LAT];

   assign rem_d[0]  = '0;
   assign root_d[0] = '0;
   assign x_d[0]    = x;

   // one result bit per stage, two radicand bits brought down each time
   for (genvar i = 0; i < SQRT_LAT; i++) begin : g_step
      logic [33:0] cur;
      logic [33:0] trial;
      logic [33:0] rem_in;
      logic [31:0] root_in;
      always_comb begin
         cur   = {rem_d[i][31:0], x_d[i][63:62]};
         trial = {root_d[i], 2'b01};
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {root_d[i][30:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {root_d[i][30:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         rem_ff[i]  <= rem_in;
         root_ff[i] <= root_in;
         x_ff[i]    <= {x_d[i][61:0], 2'b00};
      end
      assign rem_d[i+1]  = rem_ff[i];
      assign root_d[i+1] = root_ff[i];
      assign x_d[i+1]    = x_ff[i];
   end

   assign root = root_d[SQRT_LAT];
endmodule
`default_nettype wire

// File: sv/gcf_div.sv
`timescale 1ns / 1ps
`default_nettype none
module gcf_div import gcf_pkg::*; (
   input  wire logic        clock,
   input  wire logic [78:0] dividend,
   input  wire logic [31:0] divisor,
   output logic      [46:0] quot
);
   logic [31:0] r_d [DIV_LAT+1];
   logic [46:0] lo_d [DIV_LAT+1];
   logic [46:0] q_d [DIV_LAT+1];
   logic [31:0] d_d [DIV_LAT+1];
   logic [31:0] r_ff [DIV_LAT];
   logic [46:0] lo_ff [DIV_LAT];
   logic [46:0] q_ff [DIV_LAT];
   logic [31:0] d_ff [DIV_LAT];

   // top part is below the divisor whenever the quotient fits 47 bits
   assign r_d[0]  = dividend[78:47];
   assign lo_d[0] = dividend[46:0];
   assign q_d[0]  = '0;
   assign d_d[0]  = divisor;

   // restoring division, one quotient bit per stage
   for (genvar i = 0; i < DIV_LAT; i++) begin : g_step
      logic [32:0] cur;
      logic        ge;
      logic [32:0] diff;
      always_comb begin
         cur  = {r_d[i], lo_d[i][46]};
         ge   = cur >= {1'b0, d_d[i]};
         diff = cur - {1'b0, d_d[i]};
      end
      always_ff @(posedge clock) begin
         r_ff[i]  <= ge ? diff[31:0] : cur[31:0];
         lo_ff[i] <= {lo_d[i][45:0], 1'b0};
         q_ff[i]  <= {q_d[i][45:0], ge};
         d_ff[i]  <= d_d[i];
      end
      assign r_d[i+1]  = r_ff[i];
      assign lo_d[i+1] = lo_ff[i];
      assign q_d[i+1]  = q_ff[i];
      assign d_d[i+1]  = d_ff[i];
   end

   assign quot = q_d[DIV_LAT];
endmodule
`default_nettype wire

// File: sv/gcf_front.sv
`timescale 1ns / 1ps
`default_nettype none
module gcf_front import gcf_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               take,
   input  wire logic signed [31:0] foot_height,
   input  wire logic signed [31:0] vel_x,
   input  wire logic signed [31:0] vel_y,
   input  wire logic signed [31:0] vel_z,
   output logic                    out_valid,
   output fw_type                  out_word,
   output logic [2:0]              inflight
);
   logic [32:0] diff;
   logic [30:0] pen_in;
   fw_type      s1_in, s1_ff, s2_in, s2_ff, s3_ff, s4_in, s4_ff;
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic        vz1_in, vz1_ff, vz2_ff, vz3_ff;
   logic [31:0] az1_in, az1_ff;
   logic [62:0] p0_in, p0_ff;
   logic [38:0] p1_in, p1_ff;
   logic [63:0] q0_in, q0_ff;
   logic [39:0] q1_in, q1_ff;
   logic [71:0] a_in, a_ff, b_in, b_ff;
   logic [72:0] n_sum;
   logic [72:0] n_sh;

   // penetration, clamped to 0 and 31 bits
   assign diff = {cfg.level[31], cfg.level} - {foot_height[31], foot_height};
   always_comb begin
      if (diff[32] || diff == '0) pen_in = '0;
      else if (diff[31]) pen_in = '1;
      else pen_in = diff[30:0];
   end

   // magnitudes and signs of the velocity
   always_comb begin
      s1_in         = '0;
      s1_in.pen     = pen_in;
      s1_in.ax      = vel_x[31] ? (~vel_x + 32'd1) : vel_x;
      s1_in.ay      = vel_y[31] ? (~vel_y + 32'd1) : vel_y;
      s1_in.sx      = !vel_x[31] && vel_x != '0;
      s1_in.sy      = !vel_y[31] && vel_y != '0;
      az1_in        = vel_z[31] ? (~vel_z + 32'd1) : vel_z;
      vz1_in        = !vel_z[31] && vel_z != '0;
   end

   // contact test and partial products of spring and damper
   always_comb begin
      s2_in         = s1_ff;
      s2_in.contact = s1_ff.pen > cfg.minpen;
   end
   assign p0_in = cfg.stiff[31:0] * s1_ff.pen;
   assign p1_in = cfg.stiff[39:32] * s1_ff.pen;
   assign q0_in = cfg.damp[31:0] * az1_ff;
   assign q1_in = cfg.damp[39:32] * az1_ff;

   // assemble both products
   assign a_in = 72'(p0_ff) + {1'b0, p1_ff, 32'b0};
   assign b_in = 72'(q0_ff) + {q1_ff, 32'b0};

   // spring minus damper for upward velocity, spring plus damper otherwise; floored, scaled and saturated
   always_comb begin
      if (vz3_ff) n_sum = (a_ff > b_ff) ? {1'b0, a_ff - b_ff} : '0;
      else n_sum = {1'b0, a_ff} + {1'b0, b_ff};
      n_sh         = n_sum >> FRAC_BITS;
      s4_in        = s3_ff;
      s4_in.normal = sat47(n_sh[56:0]);
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      az1_ff <= az1_in;
      vz1_ff <= vz1_in;
      s2_ff  <= s2_in;
      vz2_ff <= vz1_ff;
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
      q0_ff  <= q0_in;
      q1_ff  <= q1_in;
      s3_ff  <= s2_ff;
      vz3_ff <= vz2_ff;
      a_ff   <= a_in;
      b_ff   <= b_in;
      s4_ff  <= s4_in;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= take;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_word  = s4_ff;
   assign inflight  = 3'(v1_ff) + 3'(v2_ff) + 3'(v3_ff) + 3'(v4_ff);
endmodule
`default_nettype wire

// File: sv/gcf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module gcf_queue import gcf_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire fw_type push_word,
   input  wire logic   pop,
   output logic        pop_valid,
   output fw_type      pop_word,
   output qstat_type   stat
);
   fw_type         mem_ff [QDEPTH];
   logic [QAW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QAW:0]   level_ff, level_in;
   logic           do_pop;

   assign do_pop    = pop && level_ff != '0;
   assign wr_in     = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in     = do_pop ? rd_ff + 1'b1 : rd_ff;
   assign level_in  = level_ff + (QAW+1)'(push) - (QAW+1)'(do_pop);

   // word storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_word;
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

   assign pop_valid  = level_ff != '0;
   assign pop_word   = mem_ff[rd_ff];
   assign stat.level = level_ff;
endmodule
`default_nettype wire

// File: sv/gcf_back.sv
`timescale 1ns / 1ps
`default_nettype none
module gcf_back import gcf_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire cfg_type cfg,
   input  wire logic   in_valid,
   input  wire fw_type in_word,
   output logic        in_take,
   output logic        strobe,
   output logic [30:0] penetration,
   output logic signed [47:0] force_x,
   output logic signed [47:0] force_y,
   output logic [46:0] force_z,
   output logic [46:0] friction_mag,
   output logic [31:0] slip_speed,
   output logic        slipping,
   output logic [1:0]  contact_state
);
   bk_type      p0_in, p0_ff, p1_ff, p2_ff, p4_in, p4_ff, p5_in, p5_ff, p6_ff;
   bk_type      p7_in, p7_ff, p9_in, p9_ff, p10_ff, p11_ff, p12_ff;
   bk_type      dla_ff [SQRT_LAT];
   bk_type      dlb_ff [DIV_LAT];
   logic [63:0] sqx_in, sqx_ff, sqy_in, sqy_ff, ssum_ff;
   logic [31:0] root;
   logic [20:0] coef;
   logic [52:0] frl_in, frl_ff;
   logic [35:0] frh_in, frh_ff;
   logic [67:0] fsum;
   logic [67:0] fsh;
   logic [21:0] sc1;
   logic [63:0] nxl_ff, nyl_ff;
   logic [46:0] nxh_ff, nyh_ff;
   logic [53:0] kl_ff;
   logic [36:0] kh_ff;
   logic [78:0] nx_ff, ny_ff;
   logic [68:0] k_sum, t_q;
   logic [46:0] qx, qy;
   logic [47:0] op [SQ_LANES];
   logic [47:0] hh_ff [SQ_LANES];
   logic [47:0] hl_ff [SQ_LANES];
   logic [47:0] ll_ff [SQ_LANES];
   logic [95:0] sq_ff [SQ_LANES];
   logic [96:0] h2_ff;
   logic [95:0] n2_ff, t2_ff, l2_ff, l2b_ff;
   logic [97:0] tot_ff;
   logic        slip_ff;
   logic        strobe_ff;
   logic [30:0] pen_ff;
   logic [47:0] fx_ff, fy_ff;
   logic [46:0] fz_ff, fric_ff;
   logic [31:0] speed_ff;
   logic        slipping_ff;
   logic [1:0]  state_ff;
   logic        impact;

   assign in_take = in_valid;

   // word taken from the queue
   always_comb begin
      p0_in         = '0;
      p0_in.valid   = in_valid;
      p0_in.contact = in_word.contact;
      p0_in.sx      = in_word.sx;
      p0_in.sy      = in_word.sy;
      p0_in.pen     = in_word.pen;
      p0_in.normal  = in_word.normal;
      p0_in.ax      = in_word.ax;
      p0_in.ay      = in_word.ay;
   end

   // squares of the horizontal components
   assign sqx_in = p0_ff.ax * p0_ff.ax;
   assign sqy_in = p0_ff.ay * p0_ff.ay;

   gcf_isqrt u_speed (
      .clock (clock),
      .x     (ssum_ff),
      .root  (root)
   );

   // friction coefficient by speed, then friction partial products
   always_comb begin
      p4_in       = dla_ff[SQRT_LAT-1];
      p4_in.speed = root;
      coef        = (root < {1'b0, cfg.slide}) ? cfg.scoef : cfg.dcoef;
   end
   assign frl_in = p4_in.normal[31:0] * coef;
   assign frh_in = p4_in.normal[46:32] * coef;

   // friction magnitude
   always_comb begin
      fsum       = 68'(frl_ff) + {frh_ff, 32'b0};
      fsh        = fsum >> FRAC_BITS;
      p5_in      = p4_ff;
      p5_in.fric = sat47(57'(fsh[51:0]));
   end

   assign sc1 = 22'(cfg.scoef) + 22'd1;

   // numerators and slip threshold
   always_comb begin
      k_sum       = 69'(kl_ff) + {kh_ff, 32'b0};
      t_q         = (k_sum + 69'((1 << FRAC_BITS) - 1)) >> FRAC_BITS;
      p7_in       = p6_ff;
      p7_in.t_big = t_q[68:48] != '0;
      p7_in.t_val = t_q[47:0];
   end

   gcf_div u_div_x (
      .clock    (clock),
      .dividend (nx_ff),
      .divisor  (p7_ff.speed),
      .quot     (qx)
   );

   gcf_div u_div_y (
      .clock    (clock),
      .dividend (ny_ff),
      .divisor  (p7_ff.speed),
      .quot     (qy)
   );

   // force components, zero at zero speed
   always_comb begin
      p9_in    = dlb_ff[DIV_LAT-1];
      p9_in.mx = (p9_in.speed == '0) ? '0 : qx;
      p9_in.my = (p9_in.speed == '0) ? '0 : qy;
      op[0]    = 48'(p9_in.mx);
      op[1]    = 48'(p9_in.my);
      op[2]    = 48'(p9_in.normal);
      op[3]    = p9_in.t_val;
      op[4]    = 48'(cfg.impact) + 48'd1;
   end

   // 48 bit squares from 24 bit halves
   for (genvar l = 0; l < SQ_LANES; l++) begin : g_sq
      always_ff @(posedge clock) begin
         hh_ff[l] <= op[l][47:24] * op[l][47:24];
         hl_ff[l] <= op[l][47:24] * op[l][23:0];
         ll_ff[l] <= op[l][23:0] * op[l][23:0];
         sq_ff[l] <= {hh_ff[l], 48'b0} + (96'(hl_ff[l]) << 25) + 96'(ll_ff[l]);
      end
   end

   assign impact = tot_ff >= 98'(l2b_ff);

   // arithmetic registers
   always_ff @(posedge clock) begin
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      ssum_ff <= sqx_ff + sqy_ff;
      frl_ff  <= frl_in;
      frh_ff  <= frh_in;
      nxl_ff  <= p5_ff.ax * p5_ff.fric[31:0];
      nxh_ff  <= p5_ff.ax * p5_ff.fric[46:32];
      nyl_ff  <= p5_ff.ay * p5_ff.fric[31:0];
      nyh_ff  <= p5_ff.ay * p5_ff.fric[46:32];
      kl_ff   <= p5_ff.normal[31:0] * sc1;
      kh_ff   <= p5_ff.normal[46:32] * sc1;
      nx_ff   <= 79'(nxl_ff) + {nxh_ff, 32'b0};
      ny_ff   <= 79'(nyl_ff) + {nyh_ff, 32'b0};
      h2_ff   <= 97'(sq_ff[0]) + 97'(sq_ff[1]);
      n2_ff   <= sq_ff[2];
      t2_ff   <= sq_ff[3];
      l2_ff   <= sq_ff[4];
      tot_ff  <= 98'(h2_ff) + 98'(n2_ff);
      l2b_ff  <= l2_ff;
      slip_ff <= p11_ff.contact && p11_ff.normal != '0 && !p11_ff.t_big
                 && h2_ff >= 97'(t2_ff);
   end

   // stage registers and delay lines, cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         p0_ff  <= '0;
         p1_ff  <= '0;
         p2_ff  <= '0;
         for (int i = 0; i < SQRT_LAT; i++) dla_ff[i] <= '0;
         p4_ff  <= '0;
         p5_ff  <= '0;
         p6_ff  <= '0;
         p7_ff  <= '0;
         for (int i = 0; i < DIV_LAT; i++) dlb_ff[i] <= '0;
         p9_ff  <= '0;
         p10_ff <= '0;
         p11_ff <= '0;
         p12_ff <= '0;
      end else begin
         p0_ff  <= p0_in;
         p1_ff  <= p0_ff;
         p2_ff  <= p1_ff;
         dla_ff[0] <= p2_ff;
         for (int i = 1; i < SQRT_LAT; i++) dla_ff[i] <= dla_ff[i-1];
         p4_ff  <= p4_in;
         p5_ff  <= p5_in;
         p6_ff  <= p5_ff;
         p7_ff  <= p7_in;
         dlb_ff[0] <= p7_ff;
         for (int i = 1; i < DIV_LAT; i++) dlb_ff[i] <= dlb_ff[i-1];
         p9_ff  <= p9_in;
         p10_ff <= p9_ff;
         p11_ff <= p10_ff;
         p12_ff <= p11_ff;
      end
   end

   // result register, everything but depth cleared without contact
   always_ff @(posedge clock) begin
      pen_ff      <= p12_ff.pen;
      slipping_ff <= slip_ff;
      if (p12_ff.contact) begin
         fx_ff    <= p12_ff.sx ? (48'd0 - 48'(p12_ff.mx)) : 48'(p12_ff.mx);
         fy_ff    <= p12_ff.sy ? (48'd0 - 48'(p12_ff.my)) : 48'(p12_ff.my);
         fz_ff    <= p12_ff.normal;
         fric_ff  <= p12_ff.fric;
         speed_ff <= p12_ff.speed;
         if (impact) state_ff <= ST_IMPACT;
         else if (slip_ff) state_ff <= ST_SLIP;
         else state_ff <= ST_CONTACT;
      end else begin
         fx_ff    <= '0;
         fy_ff    <= '0;
         fz_ff    <= '0;
         fric_ff  <= '0;
         speed_ff <= '0;
         state_ff <= ST_NONE;
      end
      if (reset) strobe_ff <= 1'b0;
      else strobe_ff <= p12_ff.valid;
   end

   assign strobe        = strobe_ff;
   assign penetration   = pen_ff;
   assign force_x       = fx_ff;
   assign force_y       = fy_ff;
   assign force_z       = fz_ff;
   assign friction_mag  = fric_ff;
   assign slip_speed    = speed_ff;
   assign slipping      = slipping_ff;
   assign contact_state = state_ff;
endmodule
`default_nettype wire

// File: sv/ground_contact_force_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Ground contact for one foot per word: takes height and velocity, returns penetration,
// spring-damper normal force, Coulomb friction split along x and y, slip flag and contact
// state. A new word is taken every clock cycle while busy is low, and exactly one result
// comes out per word, in order, on rsp_strobe for a single cycle, after the front, queue
// and back pipelines; the receiver cannot stall it. Most of the depth is in the
// 32-stage square root for the horizontal speed and the 47-stage dividers that split the
// friction force. Registers are written through the csr port, which is always ready;
// write them only while no word is in flight.
module ground_contact_force_top import gcf_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_foot_height,
   input  wire logic signed [31:0] req_vel_x,
   input  wire logic signed [31:0] req_vel_y,
   input  wire logic signed [31:0] req_vel_z,
   output logic                    rsp_strobe,
   output logic [30:0]             rsp_penetration,
   output logic signed [47:0]      rsp_force_x,
   output logic signed [47:0]      rsp_force_y,
   output logic [46:0]             rsp_force_z,
   output logic [46:0]             rsp_friction_mag,
   output logic [31:0]             rsp_slip_speed,
   output logic                    rsp_slipping,
   output logic [1:0]              rsp_contact_state,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [47:0]        csr_data
);
   cfg_type   cfg_ff;
   logic      take;
   logic      f_valid;
   fw_type    f_word;
   logic [2:0] inflight;
   logic      q_valid;
   fw_type    q_word;
   logic      q_pop;
   qstat_type q_stat;

   // hold off only when the queue could overflow
   assign busy      = (5'(q_stat.level) + 5'(inflight)) >= 5'(QDEPTH);
   assign take      = start && !busy;
   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level  <= 32'd1310;
         cfg_ff.minpen <= 31'd66;
         cfg_ff.stiff  <= 40'd655360000;
         cfg_ff.damp   <= 40'd65536000;
         cfg_ff.scoef  <= 21'd52429;
         cfg_ff.dcoef  <= 21'd39322;
         cfg_ff.slide  <= 31'd655;
         cfg_ff.impact <= 47'd65536000;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_LEVEL:  cfg_ff.level  <= csr_data[31:0];
            REG_MINPEN: cfg_ff.minpen <= csr_data[30:0];
            REG_STIFF:  cfg_ff.stiff  <= csr_data[39:0];
            REG_DAMP:   cfg_ff.damp   <= csr_data[39:0];
            REG_SCOEF:  cfg_ff.scoef  <= csr_data[20:0];
            REG_DCOEF:  cfg_ff.dcoef  <= csr_data[20:0];
            REG_SLIDE:  cfg_ff.slide  <= csr_data[30:0];
            REG_IMPACT: cfg_ff.impact <= csr_data[46:0];
         endcase
      end
   end

   gcf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .take        (take),
      .foot_height (req_foot_height),
      .vel_x       (req_vel_x),
      .vel_y       (req_vel_y),
      .vel_z       (req_vel_z),
      .out_valid   (f_valid),
      .out_word    (f_word),
      .inflight    (inflight)
   );

   gcf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_word (f_word),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_word  (q_word),
      .stat      (q_stat)
   );

   gcf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (q_valid),
      .in_word       (q_word),
      .in_take       (q_pop),
      .strobe        (rsp_strobe),
      .penetration   (rsp_penetration),
      .force_x       (rsp_force_x),
      .force_y       (rsp_force_y),
      .force_z       (rsp_force_z),
      .friction_mag  (rsp_friction_mag),
      .slip_speed    (rsp_slip_speed),
      .slipping      (rsp_slipping),
      .contact_state (rsp_contact_state)
   );

   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.level <= (QAW+1)'(QDEPTH))
      else $error("queue overflow");

   // no contact means no force
   a_none_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_contact_state == ST_NONE |->
         rsp_force_z == '0 && rsp_slip_speed == '0 && !rsp_slipping)
      else $error("force without contact");

   // slipping needs a normal force
   a_slip_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_slipping |-> rsp_force_z != '0)
      else $error("slip with zero normal");

   // a word pushed by the front into an empty queue is taken by the back in the next cycle
   a_drain: assert property (@(posedge clock) disable iff (reset)
      f_valid && q_stat.level == '0 |=> q_valid)
      else $error("queue lost a word");
endmodule
`default_nettype wire

// File: dv/tb_ground_contact_force_top.sv
`timescale 1ns / 1ps
module tb_ground_contact_force_top;
   import gcf_pkg::*;

   localparam int LATENCY     = 96;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_WORDS = 175;

   typedef struct {
      logic signed [31:0] height;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
   } foot_word_t;

   typedef struct {
      logic [30:0] pen;
      logic [47:0] fx;
      logic [47:0] fy;
      logic [46:0] fz;
      logic [46:0] fric;
      logic [31:0] speed;
      logic        slip;
      logic [1:0]  state;
   } contact_word_t;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_foot_height;
   logic signed [31:0] req_vel_x;
   logic signed [31:0] req_vel_y;
   logic signed [31:0] req_vel_z;
   logic               rsp_strobe;
   logic [30:0]        rsp_penetration;
   logic signed [47:0] rsp_force_x;
   logic signed [47:0] rsp_force_y;
   logic [46:0]        rsp_force_z;
   logic [46:0]        rsp_friction_mag;
   logic [31:0]        rsp_slip_speed;
   logic               rsp_slipping;
   logic [1:0]         rsp_contact_state;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [47:0]        csr_data;

   ground_contact_force_top dut (.*);

   cfg_type       ground_cfg;
   foot_word_t    pending_feet[$];
   contact_word_t expected_contacts[$];
   int            mismatches;
   int            words_sent;
   int            words_checked;
   int            contact_hits;
   int            slip_hits;
   int            impact_hits;
   int            cycles;
   int            burst_left;
   int            gap_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // floor square root, bit by bit
   function automatic logic [63:0] floor_root(input logic [127:0] x);
      logic [127:0] rem;
      logic [127:0] res;
      logic [127:0] probe;
      rem = x;
      res = '0;
      probe = 128'd1 << 126;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= res + probe) begin
            rem = rem - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res[63:0];
   endfunction

   function automatic logic [46:0] shift_sat47(input logic [127:0] v);
      logic [127:0] s;
      s = v >> FRAC_BITS;
      return (s > {81'd0, MAX47}) ? MAX47 : s[46:0];
   endfunction

   // ground contact for one foot under the current register set
   function automatic contact_word_t ground_contact(input foot_word_t f, input cfg_type c);
      contact_word_t r;
      longint        diff;
      logic [127:0]  pen, ax, ay, az, spring, damper, n, fz, fric, speed;
      logic [127:0]  mx, my, hn, s2;
      r = '{default: '0};
      diff = longint'($signed(c.level)) - longint'(f.height);
      if (diff <= 0) pen = '0;
      else if (diff > 64'h7FFF_FFFF) pen = 128'h7FFF_FFFF;
      else pen = 128'(diff);
      r.pen = pen[30:0];
      if (pen > {97'd0, c.minpen}) begin
         ax = (f.vx < 0) ? 128'(-longint'(f.vx)) : 128'(longint'(f.vx));
         ay = (f.vy < 0) ? 128'(-longint'(f.vy)) : 128'(longint'(f.vy));
         az = (f.vz < 0) ? 128'(-longint'(f.vz)) : 128'(longint'(f.vz));
         spring = 128'(c.stiff) * pen;
         damper = 128'(c.damp) * az;
         if (f.vz <= 0) n = spring + damper;
         else if (spring > damper) n = spring - damper;
         else n = '0;
         fz = 128'(shift_sat47(n));
         speed = 128'(floor_root(ax * ax + ay * ay));
         fric = 128'(shift_sat47(fz * ((speed < 128'(c.slide)) ? 128'(c.scoef)
                                                                : 128'(c.dcoef))));
         mx = '0;
         my = '0;
         if (speed != 0) begin
            mx = (ax * fric) / speed;
            my = (ay * fric) / speed;
         end
         r.fx = (f.vx > 0) ? 48'(-mx) : mx[47:0];
         r.fy = (f.vy > 0) ? 48'(-my) : my[47:0];
         r.fz = fz[46:0];
         r.fric = fric[46:0];
         r.speed = speed[31:0];
         if (fz != 0) begin
            hn = 128'(floor_root(mx * mx + my * my));
            r.slip = ((hn << FRAC_BITS) >= (128'(c.scoef) + 1) * fz);
         end
         s2 = mx * mx + my * my + fz * fz;
         if (128'(floor_root(s2)) > 128'(c.impact)) r.state = ST_IMPACT;
         else if (r.slip) r.state = ST_SLIP;
         else r.state = ST_CONTACT;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch word %0d %s: got %h want %h", words_checked, what, got, want);
      mismatches++;
   endtask

   // append a foot word to the pending list
   task automatic queue_foot(input foot_word_t f);
      pending_feet.insert(pending_feet.size(), f);
   endtask

   // driver: bursts of words with random gaps
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_feet.size() > 0) begin
         start <= 1'b1;
         req_foot_height <= pending_feet[0].height;
         req_vel_x <= pending_feet[0].vx;
         req_vel_y <= pending_feet[0].vy;
         req_vel_z <= pending_feet[0].vz;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: predict on accept, check on strobe
   always @(posedge clock) begin
      contact_word_t want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_contacts.size() == 0) begin
               report_mismatch("unexpected result", 64'd1, 64'd0);
            end else begin
               want = expected_contacts.pop_front();
               if (rsp_penetration !== want.pen)
                  report_mismatch("penetration", 64'(rsp_penetration), 64'(want.pen));
               if (rsp_force_x !== want.fx)
                  report_mismatch("force_x", 64'(rsp_force_x), 64'(want.fx));
               if (rsp_force_y !== want.fy)
                  report_mismatch("force_y", 64'(rsp_force_y), 64'(want.fy));
               if (rsp_force_z !== want.fz)
                  report_mismatch("force_z", 64'(rsp_force_z), 64'(want.fz));
               if (rsp_friction_mag !== want.fric)
                  report_mismatch("friction_mag", 64'(rsp_friction_mag), 64'(want.fric));
               if (rsp_slip_speed !== want.speed)
                  report_mismatch("slip_speed", 64'(rsp_slip_speed), 64'(want.speed));
               if (rsp_slipping !== want.slip)
                  report_mismatch("slipping", 64'(rsp_slipping), 64'(want.slip));
               if (rsp_contact_state !== want.state)
                  report_mismatch("contact_state", 64'(rsp_contact_state), 64'(want.state));
               words_checked++;
            end
         end
         if (start && !busy && pending_feet.size() > 0) begin
            want = ground_contact(pending_feet.pop_front(), ground_cfg);
            if (want.state != ST_NONE) contact_hits++;
            if (want.slip) slip_hits++;
            if (want.state == ST_IMPACT) impact_hits++;
            expected_contacts.insert(expected_contacts.size(), want);
            words_sent++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d words outstanding", expected_contacts.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_LEVEL:  ground_cfg.level  = value[31:0];
         REG_MINPEN: ground_cfg.minpen = value[30:0];
         REG_STIFF:  ground_cfg.stiff  = value[39:0];
         REG_DAMP:   ground_cfg.damp   = value[39:0];
         REG_SCOEF:  ground_cfg.scoef  = value[20:0];
         REG_DCOEF:  ground_cfg.dcoef  = value[20:0];
         REG_SLIDE:  ground_cfg.slide  = value[30:0];
         default:    ground_cfg.impact = value[46:0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      while (pending_feet.size() != 0 || expected_contacts.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_scaled();
      logic [31:0] v;
      v = $urandom >> $urandom_range(0, 31);
      return ($urandom_range(0, 1) == 1) ? -v : v;
   endfunction

   function automatic logic [47:0] rand_wide();
      logic [63:0] w;
      w = {$urandom, $urandom} >> $urandom_range(0, 63);
      return w[47:0];
   endfunction

   function automatic foot_word_t rand_foot();
      foot_word_t f;
      f.vx = rand_scaled();
      f.vy = rand_scaled();
      f.vz = rand_scaled();
      case ($urandom_range(0, 9))
         0: f = '{$urandom, $urandom, $urandom, $urandom};
         1: f.height = ground_cfg.level + $urandom_range(0, 4000);
         default: f.height = ground_cfg.level - ($urandom >> $urandom_range(8, 31));
      endcase
      if ($urandom_range(0, 9) == 0) f.vx = 0;
      if ($urandom_range(0, 9) == 0) f.vy = 0;
      return f;
   endfunction

   initial begin
      foot_word_t f;
      reset = 1'b1;
      start = 1'b0;
      req_foot_height = '0;
      req_vel_x = '0;
      req_vel_y = '0;
      req_vel_z = '0;
      csr_valid = 1'b0;
      csr_index = REG_LEVEL;
      csr_data = '0;
      mismatches = 0;
      words_sent = 0;
      words_checked = 0;
      contact_hits = 0;
      slip_hits = 0;
      impact_hits = 0;
      cycles = 0;
      ground_cfg = '{level: 32'd1310, minpen: 31'd66, stiff: 40'd655360000,
                     damp: 40'd65536000, scoef: 21'd52429, dcoef: 21'd39322,
                     slide: 31'd655, impact: 47'd65536000};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: height and speed extremes, zero speed, slip, impact, threshold
      queue_foot('{32'sh8000_0000, 0, 0, 0});
      queue_foot('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0});
      queue_foot('{1310, 100, 100, 0});
      queue_foot('{1310 - 66, 100, 0, 0});
      queue_foot('{1310 - 67, 100, 0, 0});
      queue_foot('{0, 0, 0, 0});
      queue_foot('{0, 0, 0, 32'sh8000_0000});
      queue_foot('{0, 0, 0, 32'sh7FFF_FFFF});
      queue_foot('{0, 654, 0, 0});
      queue_foot('{0, 655, 0, -1000});
      queue_foot('{0, -655, 0, 0});
      queue_foot('{0, 0, -70000, 0});
      queue_foot('{0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
      queue_foot('{0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
      queue_foot('{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000});
      queue_foot('{32'sh8000_0000, 3, -4, 5});
      queue_foot('{-65536, 1, 1, -1});
      queue_foot('{-1, -1, -1, -1});
      drain();

      // register sets: random, all ones, all zeros, reset values in between
      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p)
            1: for (int r = 0; r < 8; r++) write_reg(3'(r), {48{1'b1}});
            2: for (int r = 0; r < 8; r++) write_reg(3'(r), '0);
            3: begin
               write_reg(REG_LEVEL, 48'd1310);
               write_reg(REG_MINPEN, 48'd66);
               write_reg(REG_STIFF, 48'd655360000);
               write_reg(REG_DAMP, 48'd65536000);
               write_reg(REG_SCOEF, 48'd52429);
               write_reg(REG_DCOEF, 48'd39322);
               write_reg(REG_SLIDE, 48'd655);
               write_reg(REG_IMPACT, 48'd65536000);
            end
            default: begin
               write_reg(REG_LEVEL, 48'(rand_scaled()));
               write_reg(REG_MINPEN, 48'($urandom >> $urandom_range(1, 31)));
               write_reg(REG_STIFF, rand_wide());
               write_reg(REG_DAMP, rand_wide());
               write_reg(REG_SCOEF, 48'($urandom_range(0, 1048576)));
               write_reg(REG_DCOEF, 48'($urandom_range(0, 1048576)));
               write_reg(REG_SLIDE, 48'($urandom >> $urandom_range(1, 31)));
               write_reg(REG_IMPACT, rand_wide());
            end
         endcase
         for (int i = 0; i < PHASE_WORDS; i++) begin
            f = rand_foot();
            queue_foot(f);
         end
         drain();
      end

      $display("sent %0d foot words over %0d register sets, checked %0d results",
               words_sent, RAND_PHASES + 1, words_checked);
      $display("in contact %0d, slipping %0d, impact %0d, mismatches %0d",
               contact_hits, slip_hits, impact_hits, mismatches);
      if (mismatches == 0 && expected_contacts.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
